[rtl/assert_macros.svh]
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrqs_pkg.sv]
// shared types and constants of the round-robin quantum scheduler
package rrqs_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int REQ_W  = 2;
  localparam int TV_W   = 16;
  localparam int TIME_W = 21;
  localparam int PRE_W  = 20;
  localparam int STAT_W = 3;
  localparam int PIDX_W = 4;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [TV_W-1:0]     QUANTUM_RST = 16'd3;
  localparam logic [CFG_AW-3:0]   REG_QUANTUM = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR    = 2'd0,
    REQ_LOAD     = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_NOP      = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_ZERO_BURST = 3'd2,
    STAT_STARTED    = 3'd3,
    STAT_ALL_DONE   = 3'd4
  } status_t;

  typedef struct packed {
    logic [TV_W-1:0] arrival;
    logic [TV_W-1:0] burst;
    logic [TV_W-1:0] remaining;
  } proc_entry_t;

  typedef struct packed {
    status_t           status;
    logic [PIDX_W-1:0] proc_index;
    logic              idle_slice;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              finished;
    logic [TIME_W-1:0] wait_total;
    logic [TIME_W-1:0] turnaround;
  } slice_res_t;

endpackage

[rtl/rrqs_if.sv]
// request and result channel interfaces of the scheduler
interface rrqs_in_if;
  import rrqs_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TV_W-1:0]   arrival_time;
  logic [TV_W-1:0]   burst_time;

  modport source (output valid, output req_type, output arrival_time, output burst_time,
                  input ready);
  modport sink   (input valid, input req_type, input arrival_time, input burst_time,
                  output ready);
endinterface

interface rrqs_out_if;
  import rrqs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PIDX_W-1:0] proc_index;
  logic              idle_slice;
  logic [TIME_W-1:0] slice_start;
  logic [TIME_W-1:0] slice_end;
  logic              finished;
  logic [TIME_W-1:0] wait_total;
  logic [TIME_W-1:0] turnaround;
  logic [PRE_W-1:0]  preemptions;
  logic              all_done;

  modport source (output valid, output status, output proc_index, output idle_slice,
                  output slice_start, output slice_end, output finished,
                  output wait_total, output turnaround, output preemptions,
                  output all_done, input ready);
  modport sink   (input valid, input status, input proc_index, input idle_slice,
                  input slice_start, input slice_end, input finished,
                  input wait_total, input turnaround, input preemptions,
                  input all_done, output ready);
endinterface

[rtl/round_robin_quantum_scheduler.sv]
// top level: round-robin scheduler sequencer over the process table and ready queue rams
//
//   port       dir   protocol        carries
//   in_chan    in    valid/ready     req_type, arrival_time, burst_time
//   out_chan   out   valid/ready     slice result, preemption count, all done flag
//   cfg_*      in    apb, 1 reg      quantum at byte address 0
//
// clear, load and unknown requests pass through the response state into the registered result
// a dispatch sweeps the process table through its single read port once before and once
// after the slice; an idle unit takes only the first sweep
// no clearing pass after reset: table entries are only read below the load count
// a stalled result holds the block in its response state; no request is taken meanwhile
`include "assert_macros.svh"

module round_robin_quantum_scheduler #(
  parameter int MAX_PROCS = rrqs_pkg::MAX_PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rrqs_in_if.sink                     in_chan,
  rrqs_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rrqs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rrqs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rrqs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import rrqs_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_POP    = 7'b0000100,
    ST_FETCH  = 7'b0001000,
    ST_FINISH = 7'b0010000,
    ST_RESP   = 7'b0100000,
    ST_WAIT   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [TV_W-1:0]    quantum;
  logic [CNT_W-1:0]   loaded_cnt_r, loaded_cnt_nxt;
  logic [CNT_W-1:0]   done_cnt_r, done_cnt_nxt;
  logic [CNT_W-1:0]   fifo_cnt_r, fifo_cnt_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt, head_inc;
  logic [IDX_W-1:0]   tail_r, tail_nxt, tail_inc;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [PRE_W-1:0]   preempt_r, preempt_nxt;
  logic               started_r, started_nxt;
  logic [MAX_PROCS-1:0] queued_r, queued_nxt;
  logic [CNT_W-1:0]   scan_i_r, scan_i_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               second_r, second_nxt;
  logic               out_vld_r, out_vld_nxt;

  logic [IDX_W-1:0]   proc_r, proc_nxt;
  logic [TV_W-1:0]    arr_r, arr_nxt;
  logic [TV_W-1:0]    burst_r, burst_nxt;
  logic               rem_zero_r, rem_zero_nxt;
  slice_res_t         res_r, res_nxt;
  slice_res_t         out_res_r, out_res_nxt;
  logic [PRE_W-1:0]   out_pre_r, out_pre_nxt;
  logic               out_done_r, out_done_nxt;

  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr, tbl_raddr;
  proc_entry_t        tbl_wdata, tbl_rdata;
  logic               fq_we;
  logic [IDX_W-1:0]   fq_wdata, fq_rdata;

  logic               admit;
  logic               scan_done;
  logic [TV_W-1:0]    q_eff, slice_len, rem_new;
  logic [TIME_W-1:0]  turn;
  req_t               req;

  rrqs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .quantum (quantum)
  );

  rrqs_ram #(
    .WIDTH ($bits(proc_entry_t)),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  rrqs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PROCS)
  ) u_fifo (
    .clk   (clk),
    .we    (fq_we),
    .waddr (tail_r),
    .wdata (fq_wdata),
    .raddr (head_r),
    .rdata (fq_rdata)
  );

  assign head_inc = (head_r == IDX_W'(MAX_PROCS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == IDX_W'(MAX_PROCS - 1)) ? '0 : tail_r + 1'b1;
  assign req      = req_t'(in_chan.req_type);

  assign admit = chk_vld_r && !queued_r[chk_idx_r] && (tbl_rdata.remaining != '0) &&
                 (TIME_W'(tbl_rdata.arrival) <= time_r) &&
                 (fifo_cnt_r < CNT_W'(MAX_PROCS));
  assign scan_done = (scan_i_r >= loaded_cnt_r) && !chk_vld_r;

  assign q_eff     = (quantum == '0) ? TV_W'(1) : quantum;
  assign slice_len = (tbl_rdata.remaining < q_eff) ? tbl_rdata.remaining : q_eff;
  assign rem_new   = tbl_rdata.remaining - slice_len;
  assign turn      = time_r - TIME_W'(arr_r);

  always_comb begin
    state_nxt      = state_r;
    loaded_cnt_nxt = loaded_cnt_r;
    done_cnt_nxt   = done_cnt_r;
    fifo_cnt_nxt   = fifo_cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    time_nxt       = time_r;
    preempt_nxt    = preempt_r;
    started_nxt    = started_r;
    queued_nxt     = queued_r;
    scan_i_nxt     = scan_i_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    second_nxt     = second_r;
    out_vld_nxt    = out_vld_r && !out_chan.ready;
    proc_nxt       = proc_r;
    arr_nxt        = arr_r;
    burst_nxt      = burst_r;
    rem_zero_nxt   = rem_zero_r;
    res_nxt        = res_r;
    out_res_nxt    = out_res_r;
    out_pre_nxt    = out_pre_r;
    out_done_nxt   = out_done_r;
    tbl_we         = 1'b0;
    tbl_waddr      = proc_r;
    tbl_wdata      = tbl_rdata;
    tbl_raddr      = scan_i_r[IDX_W-1:0];
    fq_we          = 1'b0;
    fq_wdata       = proc_r;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          res_nxt        = '0;
          res_nxt.status = STAT_OK;
          state_nxt      = ST_RESP;
          case (req)
            REQ_CLEAR: begin
              loaded_cnt_nxt = '0;
              done_cnt_nxt   = '0;
              fifo_cnt_nxt   = '0;
              head_nxt       = '0;
              tail_nxt       = '0;
              time_nxt       = '0;
              preempt_nxt    = '0;
              started_nxt    = 1'b0;
              queued_nxt     = '0;
            end
            REQ_LOAD: begin
              if (started_r) begin
                res_nxt.status = STAT_STARTED;
              end else if (loaded_cnt_r >= CNT_W'(MAX_PROCS)) begin
                res_nxt.status = STAT_FULL;
              end else if (in_chan.burst_time == '0) begin
                res_nxt.status = STAT_ZERO_BURST;
              end else begin
                tbl_we              = 1'b1;
                tbl_waddr           = loaded_cnt_r[IDX_W-1:0];
                tbl_wdata.arrival   = in_chan.arrival_time;
                tbl_wdata.burst     = in_chan.burst_time;
                tbl_wdata.remaining = in_chan.burst_time;
                queued_nxt[loaded_cnt_r[IDX_W-1:0]] = 1'b0;
                res_nxt.proc_index  = PIDX_W'(loaded_cnt_r);
                loaded_cnt_nxt      = loaded_cnt_r + 1'b1;
              end
            end
            REQ_DISPATCH: begin
              if (done_cnt_r >= loaded_cnt_r) begin
                res_nxt.status = STAT_ALL_DONE;
              end else begin
                started_nxt = 1'b1;
                scan_i_nxt  = '0;
                second_nxt  = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_i_r < loaded_cnt_r) begin
          scan_i_nxt  = scan_i_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_i_r[IDX_W-1:0];
        end
        if (admit) begin
          queued_nxt[chk_idx_r] = 1'b1;
          fq_we        = 1'b1;
          fq_wdata     = chk_idx_r;
          tail_nxt     = tail_inc;
          fifo_cnt_nxt = fifo_cnt_r + 1'b1;
        end
        if (scan_done) begin
          if (second_r) begin
            state_nxt = ST_FINISH;
          end else if (fifo_cnt_r == '0) begin
            res_nxt.idle_slice  = 1'b1;
            res_nxt.slice_start = time_r;
            res_nxt.slice_end   = time_r + 1'b1;
            time_nxt            = time_r + 1'b1;
            state_nxt           = ST_RESP;
          end else begin
            head_nxt     = head_inc;
            fifo_cnt_nxt = fifo_cnt_r - 1'b1;
            state_nxt    = ST_POP;
          end
        end
      end

      ST_POP: begin
        tbl_raddr = fq_rdata;
        proc_nxt  = fq_rdata;
        state_nxt = ST_FETCH;
      end

      ST_FETCH: begin
        tbl_we              = 1'b1;
        tbl_waddr           = proc_r;
        tbl_wdata.remaining = rem_new;
        time_nxt            = time_r + TIME_W'(slice_len);
        res_nxt.proc_index  = PIDX_W'(proc_r);
        res_nxt.slice_start = time_r;
        res_nxt.slice_end   = time_r + TIME_W'(slice_len);
        arr_nxt             = tbl_rdata.arrival;
        burst_nxt           = tbl_rdata.burst;
        rem_zero_nxt        = (rem_new == '0);
        scan_i_nxt          = '0;
        second_nxt          = 1'b1;
        state_nxt           = ST_WAIT;
      end

      // table write settles before the second sweep reads slot zero
      ST_WAIT: begin
        state_nxt = ST_SCAN;
      end

      ST_FINISH: begin
        if (rem_zero_r) begin
          done_cnt_nxt       = done_cnt_r + 1'b1;
          res_nxt.finished   = 1'b1;
          res_nxt.turnaround = turn;
          res_nxt.wait_total = turn - TIME_W'(burst_r);
        end else begin
          preempt_nxt = preempt_r + 1'b1;
          if (fifo_cnt_r < CNT_W'(MAX_PROCS)) begin
            fq_we        = 1'b1;
            fq_wdata     = proc_r;
            tail_nxt     = tail_inc;
            fifo_cnt_nxt = fifo_cnt_r + 1'b1;
          end
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt  = 1'b1;
          out_res_nxt  = res_r;
          out_pre_nxt  = preempt_r;
          out_done_nxt = (done_cnt_r == loaded_cnt_r);
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      loaded_cnt_r <= '0;
      done_cnt_r   <= '0;
      fifo_cnt_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      time_r       <= '0;
      preempt_r    <= '0;
      started_r    <= 1'b0;
      queued_r     <= '0;
      scan_i_r     <= '0;
      chk_vld_r    <= 1'b0;
      second_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_cnt_r <= loaded_cnt_nxt;
      done_cnt_r   <= done_cnt_nxt;
      fifo_cnt_r   <= fifo_cnt_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      time_r       <= time_nxt;
      preempt_r    <= preempt_nxt;
      started_r    <= started_nxt;
      queued_r     <= queued_nxt;
      scan_i_r     <= scan_i_nxt;
      chk_vld_r    <= chk_vld_nxt;
      second_r     <= second_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    proc_r     <= proc_nxt;
    arr_r      <= arr_nxt;
    burst_r    <= burst_nxt;
    rem_zero_r <= rem_zero_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
    out_pre_r  <= out_pre_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_chan.ready = (state_r == ST_IDLE);

  assign out_chan.valid       = out_vld_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.proc_index  = out_res_r.proc_index;
  assign out_chan.idle_slice  = out_res_r.idle_slice;
  assign out_chan.slice_start = out_res_r.slice_start;
  assign out_chan.slice_end   = out_res_r.slice_end;
  assign out_chan.finished    = out_res_r.finished;
  assign out_chan.wait_total  = out_res_r.wait_total;
  assign out_chan.turnaround  = out_res_r.turnaround;
  assign out_chan.preemptions = out_pre_r;
  assign out_chan.all_done    = out_done_r;

  `ASSERT_ALWAYS(a_fifo_bound, clk, rst_n, fifo_cnt_r <= CNT_W'(MAX_PROCS),
                 "ready queue overfilled")
  `ASSERT_ALWAYS(a_done_bound, clk, rst_n, done_cnt_r <= loaded_cnt_r,
                 "more done than loaded")
  `ASSERT_IMPL(a_queue_account, clk, rst_n, state_r == ST_IDLE,
               32'(fifo_cnt_r) + 32'(done_cnt_r) == $countones(queued_r),
               "queued process lost or duplicated")
  `ASSERT_IMPL(a_pop_loaded, clk, rst_n, state_r == ST_FETCH,
               CNT_W'(proc_r) < loaded_cnt_r, "popped index beyond table")
  `ASSERT_NEXT(a_dispatch_starts, clk, rst_n,
               in_chan.valid && in_chan.ready && req == REQ_DISPATCH &&
               done_cnt_r < loaded_cnt_r,
               started_r, "dispatch did not start run")
endmodule

[rtl/rrqs_ram.sv]
// generic single write port, single read port ram with registered read
module rrqs_ram #(
  parameter int WIDTH = rrqs_pkg::TV_W,
  parameter int DEPTH = rrqs_pkg::MAX_PROCS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[rtl/rrqs_cfg.sv]
// apb register block holding the time quantum
module rrqs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrqs_pkg::CFG_AW-1:0] paddr,
  input  logic [rrqs_pkg::CFG_DW-1:0] pwdata,
  output logic [rrqs_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [rrqs_pkg::TV_W-1:0]   quantum
);
  import rrqs_pkg::*;

  logic [TV_W-1:0] quantum_r;
  logic            hit;
  logic            wr_en;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_AW-1:2] == REG_QUANTUM);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else if (wr_en) begin
      quantum_r <= pwdata[TV_W-1:0];
    end
  end

  assign prdata  = hit ? CFG_DW'(quantum_r) : '0;
  assign quantum = quantum_r;
endmodule
